// ===== rtl/text_mode_display_buffer_core_assert.svh =====
// Assertion macros for the display buffer core.
// They expect clk_i and rst_ni in the scope of use.
`ifndef TEXT_MODE_DISPLAY_BUFFER_CORE_ASSERT_SVH
`define TEXT_MODE_DISPLAY_BUFFER_CORE_ASSERT_SVH

`define TMDB_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

`define TMDB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define TMDB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tmdb_pkg.sv =====
`default_nettype none

package tmdb_pkg;

  localparam int DefaultCols = 32;
  localparam int DefaultRows = 16;

  localparam int ModeW  = 4;
  localparam int CharW  = 8;
  localparam int ColorW = 8;
  localparam int ValueW = 8;

  localparam logic [ColorW-1:0] DefaultColorRst = 8'd15;

  typedef enum logic [ModeW-1:0] {
    ModePrint   = 4'd0,
    ModeNewline = 4'd1,
    ModeFg      = 4'd2,
    ModeBg      = 4'd3,
    ModeCol     = 4'd4,
    ModeRow     = 4'd5,
    ModeClear   = 4'd6,
    ModeRefresh = 4'd7,
    ModeReset   = 4'd8,
    ModeRead    = 4'd9
  } mode_e;

endpackage

`default_nettype wire

// ===== rtl/tmdb_if.sv =====
`default_nettype none

interface tmdb_cmd_if #(
  parameter int COLS = tmdb_pkg::DefaultCols,
  parameter int ROWS = tmdb_pkg::DefaultRows
);
  import tmdb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [ModeW-1:0]          mode;
  logic [ValueW-1:0]         value;
  logic [$clog2(ROWS)-1:0]   read_row;
  logic [$clog2(COLS)-1:0]   read_col;

  modport source (output valid, output mode, output value, output read_row,
                  output read_col, input ready);
  modport sink   (input valid, input mode, input value, input read_row,
                  input read_col, output ready);
endinterface

interface tmdb_rsp_if #(
  parameter int COLS = tmdb_pkg::DefaultCols,
  parameter int ROWS = tmdb_pkg::DefaultRows
);
  import tmdb_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [$clog2(COLS+1)-1:0]   cursor_col;
  logic [$clog2(ROWS+1)-1:0]   cursor_row;
  logic [ColorW-1:0]           current_color;
  logic [CharW-1:0]            cell_char;
  logic [ColorW-1:0]           cell_color;

  modport source (output valid, output cursor_col, output cursor_row,
                  output current_color, output cell_char, output cell_color,
                  input ready);
  modport sink   (input valid, input cursor_col, input cursor_row,
                  input current_color, input cell_char, input cell_color,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/tmdb_ram.sv =====
`default_nettype none

module tmdb_ram #(
  parameter int AW = 9,
  parameter int DW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/text_mode_display_buffer_core.sv =====
// Most commands pass through StExec and StDone, where the result is registered; a new
// transfer is taken only in StIdle, or in StDone once the output slot is free. A shown-cell
// read passes through StExec, StRead and StDone. Scroll and refresh sweep all ROWS*COLS cells
// through one address counter, then pass StFlush; a print with scroll then writes in StPut.
// After reset a clearing pass over all ROWS*COLS cells zeroes both buffers before the
// first transfer; configuration writes are taken throughout.
`default_nettype none
`include "text_mode_display_buffer_core_assert.svh"

module text_mode_display_buffer_core #(
  parameter int COLS = tmdb_pkg::DefaultCols,
  parameter int ROWS = tmdb_pkg::DefaultRows
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tmdb_pkg::ColorW-1:0]   cfg_data_i,
  tmdb_cmd_if.sink                      cmd_i,
  tmdb_rsp_if.source                    rsp_o
);
  import tmdb_pkg::*;

  localparam int Cells = COLS * ROWS;
  localparam int AW    = $clog2(Cells);
  localparam int CCW   = $clog2(COLS + 1);
  localparam int CRW   = $clog2(ROWS + 1);
  localparam int CRW1  = CRW + 1;
  localparam int RCW   = $clog2(COLS);
  localparam int RRW   = $clog2(ROWS);
  localparam int DW    = CharW + ColorW;

  localparam logic [AW-1:0]  LastAddr  = AW'(Cells - 1);
  localparam logic [AW-1:0]  ScrollLim = AW'(Cells - COLS);
  localparam logic [AW-1:0]  ColsA     = AW'(COLS);
  localparam logic [CCW-1:0] ColsC     = CCW'(COLS);
  localparam logic [CRW-1:0] RowsC     = CRW'(ROWS);
  localparam logic [CRW-1:0] LastRowC  = CRW'(ROWS - 1);
  localparam logic [CRW:0]   RowsW     = CRW1'(ROWS);
  localparam logic [RRW-1:0] LastRow   = RRW'(ROWS - 1);

  typedef enum logic [3:0] {
    StIdle, StExec, StScroll, StCopy, StFlush, StPut, StWipe, StRead, StDone
  } state_e;

  typedef struct packed {
    logic          valid;
    logic          to_shown;
    logic          zero;
    logic [AW-1:0] addr;
  } pipe_t;

  state_e             state_q;
  logic [ModeW-1:0]   mode_q;
  logic [ValueW-1:0]  value_q;
  logic [RRW-1:0]     rrow_q;
  logic [RCW-1:0]     rcol_q;
  logic [CCW-1:0]     col_q;
  logic [CRW-1:0]     row_q;
  logic [ColorW-1:0]  pen_q;
  logic [ColorW-1:0]  dflt_q;
  logic [AW-1:0]      addr_q;
  logic               wipe_shown_q;
  logic               init_q;
  logic [CharW-1:0]   cell_char_q;
  logic [ColorW-1:0]  cell_color_q;
  pipe_t              pipe_q;
  pipe_t              pipe_d;
  logic               out_valid_q;
  logic [CCW-1:0]     out_col_q;
  logic [CRW-1:0]     out_row_q;
  logic [ColorW-1:0]  out_color_q;
  logic [CharW-1:0]   out_char_q;
  logic [ColorW-1:0]  out_cell_color_q;

  logic               cmd_accept;
  logic               slot_free;
  logic               col_wrap;
  logic [CCW-1:0]     c_w;
  logic [CRW:0]       r_w;
  logic               need_scroll;
  logic               read_ok;
  logic [RRW-1:0]     idx_row;
  logic [RCW-1:0]     idx_col;
  logic [AW-1:0]      idx;

  logic               p_we;
  logic [AW-1:0]      p_waddr;
  logic [DW-1:0]      p_wdata;
  logic               p_re;
  logic [AW-1:0]      p_raddr;
  logic [DW-1:0]      p_rdata;
  logic               s_we;
  logic [AW-1:0]      s_waddr;
  logic [DW-1:0]      s_wdata;
  logic               s_re;
  logic [DW-1:0]      s_rdata;

  assign slot_free  = !out_valid_q || rsp_o.ready;
  assign cmd_i.ready = (state_q == StIdle) || (state_q == StDone && slot_free);
  assign cmd_accept = cmd_i.valid && cmd_i.ready;

  // A print first wraps the cursor at the end of the row.
  assign col_wrap    = col_q >= ColsC;
  assign c_w         = col_wrap ? '0 : col_q;
  assign r_w         = {1'b0, row_q} + {{CRW{1'b0}}, col_wrap};
  assign need_scroll = r_w >= RowsW;
  assign read_ok     = (int'(rrow_q) < ROWS) && (int'(rcol_q) < COLS);

  // Shared cell index unit for print, the write after a scroll and the shown read.
  always_comb begin
    if (state_q == StPut) begin
      idx_row = LastRow;
      idx_col = col_q[RCW-1:0];
    end else if (mode_q == ModeRead) begin
      idx_row = rrow_q;
      idx_col = rcol_q;
    end else begin
      idx_row = r_w[RRW-1:0];
      idx_col = c_w[RCW-1:0];
    end
    idx = AW'(idx_row) * ColsA + AW'(idx_col);
  end

  always_comb begin
    pipe_d = '0;
    if (state_q == StScroll) begin
      pipe_d.valid = 1'b1;
      pipe_d.zero  = addr_q >= ScrollLim;
      pipe_d.addr  = addr_q;
    end else if (state_q == StCopy) begin
      pipe_d.valid    = 1'b1;
      pipe_d.to_shown = 1'b1;
      pipe_d.addr     = addr_q;
    end
  end

  always_comb begin
    p_we    = 1'b0;
    p_waddr = addr_q;
    p_wdata = '0;
    p_re    = 1'b0;
    p_raddr = addr_q;
    s_we    = 1'b0;
    s_waddr = addr_q;
    s_wdata = '0;
    s_re    = 1'b0;

    if (pipe_q.valid) begin
      if (pipe_q.to_shown) begin
        s_we    = 1'b1;
        s_waddr = pipe_q.addr;
        s_wdata = p_rdata;
      end else begin
        p_we    = 1'b1;
        p_waddr = pipe_q.addr;
        p_wdata = pipe_q.zero ? '0 : p_rdata;
      end
    end

    unique case (state_q)
      StExec: begin
        if (mode_q == ModePrint && !need_scroll) begin
          p_we    = 1'b1;
          p_waddr = idx;
          p_wdata = {value_q, pen_q};
        end
        if (mode_q == ModeRead && read_ok) begin
          s_re = 1'b1;
        end
      end
      StPut: begin
        p_we    = 1'b1;
        p_waddr = idx;
        p_wdata = {value_q, pen_q};
      end
      StWipe: begin
        p_we = 1'b1;
        s_we = wipe_shown_q;
      end
      StScroll: begin
        p_re    = addr_q < ScrollLim;
        p_raddr = addr_q + ColsA;
      end
      StCopy: begin
        p_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  tmdb_ram #(
    .AW (AW),
    .DW (DW)
  ) u_paint (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .re_i    (p_re),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  tmdb_ram #(
    .AW (AW),
    .DW (DW)
  ) u_shown (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (idx),
    .rdata_o (s_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= StWipe;
      init_q           <= 1'b1;
      wipe_shown_q     <= 1'b1;
      addr_q           <= '0;
      mode_q           <= '0;
      value_q          <= '0;
      rrow_q           <= '0;
      rcol_q           <= '0;
      col_q            <= '0;
      row_q            <= '0;
      pen_q            <= DefaultColorRst;
      dflt_q           <= DefaultColorRst;
      cell_char_q      <= '0;
      cell_color_q     <= '0;
      pipe_q           <= '0;
      out_valid_q      <= 1'b0;
      out_col_q        <= '0;
      out_row_q        <= '0;
      out_color_q      <= '0;
      out_char_q       <= '0;
      out_cell_color_q <= '0;
    end else begin
      pipe_q <= pipe_d;
      if (cfg_we_i) begin
        dflt_q <= cfg_data_i;
      end
      if (rsp_o.valid && rsp_o.ready && state_q != StDone) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_accept) begin
        mode_q  <= cmd_i.mode;
        value_q <= cmd_i.value;
        rrow_q  <= cmd_i.read_row;
        rcol_q  <= cmd_i.read_col;
      end

      unique case (state_q)
        StIdle: begin
          if (cmd_accept) begin
            state_q <= StExec;
          end
        end
        StExec: begin
          cell_char_q  <= '0;
          cell_color_q <= '0;
          addr_q       <= '0;
          unique case (mode_q)
            ModePrint: begin
              if (need_scroll) begin
                col_q   <= c_w;
                row_q   <= LastRowC;
                state_q <= StScroll;
              end else begin
                col_q   <= c_w + CCW'(1);
                row_q   <= r_w[CRW-1:0];
                state_q <= StDone;
              end
            end
            ModeNewline: begin
              col_q <= '0;
              if (row_q >= RowsC) begin
                row_q   <= RowsC;
                state_q <= StScroll;
              end else begin
                row_q   <= row_q + CRW'(1);
                state_q <= StDone;
              end
            end
            ModeFg: begin
              pen_q   <= {pen_q[7:4], value_q[3:0]};
              state_q <= StDone;
            end
            ModeBg: begin
              pen_q   <= {value_q[3:0], pen_q[3:0]};
              state_q <= StDone;
            end
            ModeCol: begin
              if (int'(value_q) < COLS) begin
                col_q <= CCW'(value_q);
              end
              state_q <= StDone;
            end
            ModeRow: begin
              if (int'(value_q) < ROWS) begin
                row_q <= CRW'(value_q);
              end
              state_q <= StDone;
            end
            ModeClear: begin
              wipe_shown_q <= 1'b0;
              state_q      <= StWipe;
            end
            ModeRefresh: begin
              state_q <= StCopy;
            end
            ModeReset: begin
              pen_q        <= dflt_q;
              col_q        <= '0;
              row_q        <= '0;
              wipe_shown_q <= 1'b1;
              state_q      <= StWipe;
            end
            ModeRead: begin
              if (read_ok) begin
                state_q <= StRead;
              end else begin
                state_q <= StDone;
              end
            end
            default: begin
              state_q <= StDone;
            end
          endcase
        end
        StScroll, StCopy: begin
          addr_q <= addr_q + AW'(1);
          if (addr_q == LastAddr) begin
            state_q <= StFlush;
          end
        end
        StFlush: begin
          state_q <= (mode_q == ModePrint) ? StPut : StDone;
        end
        StPut: begin
          col_q   <= col_q + CCW'(1);
          state_q <= StDone;
        end
        StWipe: begin
          addr_q <= addr_q + AW'(1);
          if (addr_q == LastAddr) begin
            if (init_q) begin
              init_q  <= 1'b0;
              state_q <= StIdle;
            end else begin
              state_q <= StDone;
            end
          end
        end
        StRead: begin
          cell_char_q  <= s_rdata[DW-1:ColorW];
          cell_color_q <= s_rdata[ColorW-1:0];
          state_q      <= StDone;
        end
        StDone: begin
          if (slot_free) begin
            out_valid_q      <= 1'b1;
            out_col_q        <= col_q;
            out_row_q        <= row_q;
            out_color_q      <= pen_q;
            out_char_q       <= cell_char_q;
            out_cell_color_q <= cell_color_q;
            state_q          <= cmd_accept ? StExec : StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.cursor_col    = out_col_q;
  assign rsp_o.cursor_row    = out_row_q;
  assign rsp_o.current_color = out_color_q;
  assign rsp_o.cell_char     = out_char_q;
  assign rsp_o.cell_color    = out_cell_color_q;

  `TMDB_ASSERT_NEXT(a_accept_exec, cmd_accept, state_q == StExec, "transfer did not start execution")
  `TMDB_ASSERT_ALWAYS(a_cursor_range, (col_q <= ColsC) && (row_q <= RowsC), "cursor out of range")
  `TMDB_ASSERT_IMPL(a_pipe_state, pipe_q.valid, (state_q == StScroll) || (state_q == StCopy) || (state_q == StFlush), "sweep write outside a sweep")

endmodule

`default_nettype wire
